FILE: src/mpwd_pkg.sv
// ----------------------------------------------------------------------------
// mpwd_pkg
// Shared constants, codes and types of the Manchester pulse-width decoder.
// ----------------------------------------------------------------------------
package mpwd_pkg;

    // decoded shift register width, the low 32 bits are reported
    localparam int DATA_BITS  = 32;
    localparam int OUT_DATA_W = 32;

    localparam int DUR_W      = 15;
    localparam int CNT_W      = 6;
    localparam int STATUS_W   = 3;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;

    localparam logic [DUR_W-1:0] RST_HALF_BIT = 15'd416;
    localparam logic [DUR_W-1:0] RST_FULL_BIT = 15'd833;
    localparam logic [DUR_W-1:0] RST_TOL      = 15'd105;

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SECOND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ENDS_LOW    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_WIDTH   = 3'd4;

    // decoder phases
    localparam logic [PHASE_W-1:0] PH_START  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_EDGE   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd3;

    // queue between classifier and decoder
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic level;
        logic last;
        logic filler;
        logic half;
        logic full;
    } t_pulse_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    // n - tol < d < n + tol, evaluated without wrap
    function automatic logic in_window(input logic [DUR_W-1:0] d,
                                       input logic [DUR_W-1:0] n,
                                       input logic [DUR_W-1:0] tol);
        logic [DUR_W:0] d_plus;
        logic [DUR_W:0] n_plus;
        d_plus = {1'b0, d} + {1'b0, tol};
        n_plus = {1'b0, n} + {1'b0, tol};
        return (d_plus > {1'b0, n}) && ({1'b0, d} < n_plus);
    endfunction

endpackage

FILE: src/manchester_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// manchester_pulse_width_decoder
// Decodes Manchester frames from measured line pulses, one result per frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  tdata: level, duration; tlast: frame end
//  m_       out  m_tvalid / m_tready  tdata: status, frame_data, bit_count
//  cfg      in   i_cfg_valid / o_cfg_ready  index, 15-bit value
//
//  one pulse per cycle sustained; a pulse reaches the decoder through a
//  four-entry queue once written there, a result appears the cycle after its
//  frame-end pulse is decoded. s_tready drops only when the queue is full,
//  which happens only while a result waits on m_tready. synchronous reset
//  clears the queue, decoder state and result slot and restores the timings.
// ----------------------------------------------------------------------------
module manchester_pulse_width_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [0] pulse_level, [15:1] pulse_duration
    input  logic                             s_tlast,   // frame_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // [2:0] status, [34:3] frame_data,
                                                        // [40:35] bit_count, [47:41] zero
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mpwd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mpwd_pkg::DUR_W-1:0]       i_cfg_data
);

    mpwd_pkg::t_pulse_cls          w_cls_in;
    mpwd_pkg::t_pulse_cls          w_cls_out;
    mpwd_pkg::t_fifo_st            w_fifo_st;
    logic                          w_push;
    logic                          w_pop;
    logic [mpwd_pkg::STATUS_W-1:0]   w_status;
    logic [mpwd_pkg::OUT_DATA_W-1:0] w_frame_data;
    logic [mpwd_pkg::CNT_W-1:0]      w_bit_count;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !w_fifo_st.full;
    assign w_push      = s_tvalid && s_tready;

    mpwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_level     (s_tdata[0]),
        .i_duration  (s_tdata[15:1]),
        .i_last      (s_tlast),
        .o_cls       (w_cls_in)
    );

    mpwd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_cls_in),
        .i_pop   (w_pop),
        .o_dout  (w_cls_out),
        .o_st    (w_fifo_st)
    );

    mpwd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!w_fifo_st.empty),
        .i_cls        (w_cls_out),
        .o_pop        (w_pop),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_status     (w_status),
        .o_frame_data (w_frame_data),
        .o_bit_count  (w_bit_count)
    );

    assign m_tdata = {7'd0, w_bit_count, w_frame_data, w_status};

    // decoder never pulls from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_st.empty)
        else $error("pop from empty queue");

    // failed frames report no data and no count
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (w_status != mpwd_pkg::ST_OK)) |->
        ((w_frame_data == '0) && (w_bit_count == '0)))
        else $error("error result carries data");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (w_status <= mpwd_pkg::ST_BAD_WIDTH))
        else $error("status out of range");

    // an empty queue after reset leaves no result
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result right after reset");

endmodule

FILE: src/mpwd_front.sv
// ----------------------------------------------------------------------------
// mpwd_front
// Holds the timing registers and classifies each incoming pulse.
// ----------------------------------------------------------------------------
module mpwd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpwd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpwd_pkg::DUR_W-1:0]        i_cfg_data,
    input  logic                              i_level,
    input  logic [mpwd_pkg::DUR_W-1:0]        i_duration,
    input  logic                              i_last,
    output mpwd_pkg::t_pulse_cls              o_cls
);

    logic [mpwd_pkg::DUR_W-1:0] r_half_bit;
    logic [mpwd_pkg::DUR_W-1:0] r_full_bit;
    logic [mpwd_pkg::DUR_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit <= mpwd_pkg::RST_HALF_BIT;
            r_full_bit <= mpwd_pkg::RST_FULL_BIT;
            r_tol      <= mpwd_pkg::RST_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mpwd_pkg::CFG_HALF_BIT: r_half_bit <= i_cfg_data;
                mpwd_pkg::CFG_FULL_BIT: r_full_bit <= i_cfg_data;
                mpwd_pkg::CFG_TOL:      r_tol      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cls.level  = i_level;
        o_cls.last   = i_last;
        // zero-length low pulse at frame end pads the frame
        o_cls.filler = i_last && !i_level && (i_duration == '0);
        o_cls.half   = mpwd_pkg::in_window(i_duration, r_half_bit, r_tol);
        o_cls.full   = mpwd_pkg::in_window(i_duration, r_full_bit, r_tol);
    end

endmodule

FILE: src/mpwd_fifo.sv
// ----------------------------------------------------------------------------
// mpwd_fifo
// Short queue of classified pulses between classifier and decoder.
// ----------------------------------------------------------------------------
module mpwd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mpwd_pkg::t_pulse_cls  i_din,
    input  logic                  i_pop,
    output mpwd_pkg::t_pulse_cls  o_dout,
    output mpwd_pkg::t_fifo_st    o_st
);

    localparam int AW = mpwd_pkg::FIFO_AW;

    mpwd_pkg::t_pulse_cls r_mem [mpwd_pkg::FIFO_DEPTH];
    logic [AW-1:0]        r_wr_ptr;
    logic [AW-1:0]        r_rd_ptr;
    logic [AW:0]          r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_dout   = r_mem[r_rd_ptr];
    assign o_st.full  = (r_count == (AW+1)'(mpwd_pkg::FIFO_DEPTH));
    assign o_st.empty = (r_count == '0);

endmodule

FILE: src/mpwd_back.sv
// ----------------------------------------------------------------------------
// mpwd_back
// Frame decoder state machine with a registered result slot.
// ----------------------------------------------------------------------------
module mpwd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  mpwd_pkg::t_pulse_cls               i_cls,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mpwd_pkg::STATUS_W-1:0]      o_status,
    output logic [mpwd_pkg::OUT_DATA_W-1:0]    o_frame_data,
    output logic [mpwd_pkg::CNT_W-1:0]         o_bit_count
);

    localparam int DB = mpwd_pkg::DATA_BITS;

    logic [mpwd_pkg::PHASE_W-1:0]    r_phase,   n_phase;
    logic                            r_bit,     n_bit;
    logic                            r_pending, n_pending;
    logic [DB-1:0]                   r_shift,   n_shift;
    logic [mpwd_pkg::CNT_W-1:0]      r_count,   n_count;
    logic [mpwd_pkg::STATUS_W-1:0]   r_err,     n_err;

    logic                            r_out_valid;
    logic [mpwd_pkg::STATUS_W-1:0]   r_out_status;
    logic [mpwd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [mpwd_pkg::CNT_W-1:0]      r_out_count;

    logic        w_slot_free;
    logic        w_shift_en;
    logic        w_shift_bit;
    logic        w_emit;
    logic [63:0] w_shift_ext;

    assign w_slot_free = !r_out_valid || i_ready;
    // pulses that close no frame never wait on the result slot
    assign o_pop  = i_valid && (!i_cls.last || w_slot_free);
    assign w_emit = o_pop && i_cls.last;

    always_comb begin
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_pending   = r_pending;
        n_err       = r_err;
        w_shift_en  = 1'b0;
        w_shift_bit = r_bit;
        case (r_phase)
            mpwd_pkg::PH_START: begin
                if (i_cls.filler || !(i_cls.level && i_cls.half)) begin
                    n_err   = mpwd_pkg::ST_BAD_START;
                    n_phase = mpwd_pkg::PH_SKIP;
                end else begin
                    n_phase = mpwd_pkg::PH_EDGE;
                end
            end
            mpwd_pkg::PH_EDGE: begin
                if (i_cls.filler) begin
                    n_phase = r_phase;
                end else if (i_cls.half) begin
                    if (i_cls.last) begin
                        // lone trailing half-bit must be high
                        if (!i_cls.level) begin
                            n_err   = mpwd_pkg::ST_ENDS_LOW;
                            n_phase = mpwd_pkg::PH_SKIP;
                        end
                    end else begin
                        n_pending = i_cls.level;
                        n_phase   = mpwd_pkg::PH_SECOND;
                    end
                end else if (i_cls.full) begin
                    n_bit       = !r_bit;
                    w_shift_en  = 1'b1;
                    w_shift_bit = !r_bit;
                end else begin
                    n_err   = mpwd_pkg::ST_BAD_WIDTH;
                    n_phase = mpwd_pkg::PH_SKIP;
                end
            end
            mpwd_pkg::PH_SECOND: begin
                if (i_cls.filler) begin
                    if (!r_pending) begin
                        n_err   = mpwd_pkg::ST_ENDS_LOW;
                        n_phase = mpwd_pkg::PH_SKIP;
                    end
                end else if (!i_cls.half) begin
                    n_err   = mpwd_pkg::ST_BAD_SECOND;
                    n_phase = mpwd_pkg::PH_SKIP;
                end else begin
                    w_shift_en  = 1'b1;
                    w_shift_bit = r_bit;
                    n_phase     = mpwd_pkg::PH_EDGE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        n_shift = r_shift;
        n_count = r_count;
        if (w_shift_en) begin
            n_shift = {r_shift[DB-2:0], w_shift_bit};
            if (r_count != mpwd_pkg::CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign w_shift_ext = 64'(n_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mpwd_pkg::PH_START;
            r_bit     <= 1'b1;
            r_pending <= 1'b0;
            r_shift   <= '0;
            r_count   <= '0;
            r_err     <= mpwd_pkg::ST_OK;
        end else if (w_emit) begin
            r_phase   <= mpwd_pkg::PH_START;
            r_bit     <= 1'b1;
            r_pending <= 1'b0;
            r_shift   <= '0;
            r_count   <= '0;
            r_err     <= mpwd_pkg::ST_OK;
        end else if (o_pop) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_pending <= n_pending;
            r_shift   <= n_shift;
            r_count   <= n_count;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= n_err;
            if (n_err == mpwd_pkg::ST_OK) begin
                r_out_data  <= w_shift_ext[mpwd_pkg::OUT_DATA_W-1:0];
                r_out_count <= n_count;
            end else begin
                r_out_data  <= '0;
                r_out_count <= '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_frame_data = r_out_data;
    assign o_bit_count  = r_out_count;

endmodule
